@@ hw/rtl/tcf_pkg.sv @@
package tcf_pkg;

  localparam int CORDIC_ITERATIONS = 16;
  localparam int ATAN_TABLE_SIZE = 24;
  localparam int CORDIC_N = (CORDIC_ITERATIONS > ATAN_TABLE_SIZE) ?
                            ATAN_TABLE_SIZE : CORDIC_ITERATIONS;
  localparam int SQRT_W = 48;
  localparam int SQRT_STEPS = SQRT_W / 2;
  localparam int CNT_W = 5;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_GYRO_OFFSET_X   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GYRO_OFFSET_Y   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLEND_WEIGHT    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GYRO_STEP_SCALE = 2'd3;

  localparam logic [15:0] BLEND_WEIGHT_RST = 16'd62587;
  localparam logic [15:0] STEP_SCALE_RST   = 16'd10230;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SQ_A, ST_SQ_B, ST_SQRT, ST_CINIT, ST_CORDIC,
    ST_DELTA, ST_BLEND_W, ST_BLEND_C, ST_EST, ST_OUT
  } tcf_state_t;

  typedef enum logic [3:0] {
    OP_NOP, OP_LOAD, OP_SQ_A, OP_SQ_B, OP_SQRT, OP_CINIT, OP_CORDIC,
    OP_DELTA, OP_BLEND_W, OP_BLEND_C, OP_EST, OP_OUT
  } tcf_op_t;

  typedef struct packed {
    tcf_op_t          op;
    logic             axis;
    logic [CNT_W-1:0] iter;
    logic             take;
  } tcf_cmd_t;

  typedef struct packed {
    logic in_valid;
    logic out_free;
  } tcf_stat_t;

  function automatic logic signed [24:0] atan_q16(input logic [CNT_W-1:0] i);
    logic signed [24:0] v;
    case (i)
      5'd0:  v = 25'sd2949120;
      5'd1:  v = 25'sd1740967;
      5'd2:  v = 25'sd919879;
      5'd3:  v = 25'sd466945;
      5'd4:  v = 25'sd234379;
      5'd5:  v = 25'sd117304;
      5'd6:  v = 25'sd58666;
      5'd7:  v = 25'sd29335;
      5'd8:  v = 25'sd14668;
      5'd9:  v = 25'sd7334;
      5'd10: v = 25'sd3667;
      5'd11: v = 25'sd1833;
      5'd12: v = 25'sd917;
      5'd13: v = 25'sd458;
      5'd14: v = 25'sd229;
      5'd15: v = 25'sd115;
      5'd16: v = 25'sd57;
      5'd17: v = 25'sd29;
      5'd18: v = 25'sd14;
      5'd19: v = 25'sd7;
      5'd20: v = 25'sd4;
      5'd21: v = 25'sd2;
      5'd22: v = 25'sd1;
      default: v = 25'sd0;
    endcase
    return v;
  endfunction

endpackage

@@ hw/rtl/tcf_in_if.sv @@
interface tcf_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] accel_x;
  logic signed [15:0] accel_y;
  logic signed [15:0] accel_z;
  logic signed [15:0] rate_x;
  logic signed [15:0] rate_y;

  modport source (output valid, accel_x, accel_y, accel_z, rate_x, rate_y,
                  input ready);
  modport sink (input valid, accel_x, accel_y, accel_z, rate_x, rate_y,
                output ready);
endinterface

@@ hw/rtl/tcf_out_if.sv @@
interface tcf_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] pitch_deg;
  logic signed [15:0] roll_deg;

  modport source (output valid, pitch_deg, roll_deg, input ready);
  modport sink (input valid, pitch_deg, roll_deg, output ready);
endinterface

@@ hw/rtl/tcf_cfg_if.sv @@
interface tcf_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [tcf_pkg::CFG_IDX_W-1:0]  idx;
  logic [15:0]                    data;

  modport source (output valid, idx, data, input ready);
  modport sink (input valid, idx, data, output ready);
endinterface

@@ hw/rtl/tcf_ctrl.sv @@
module tcf_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  tcf_pkg::tcf_stat_t  stat,
  output tcf_pkg::tcf_cmd_t   cmd
);

  tcf_pkg::tcf_state_t           state_r, state_nxt;
  logic [tcf_pkg::CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                          axis_r, axis_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tcf_pkg::ST_IDLE;
      cnt_r   <= '0;
      axis_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      axis_r  <= axis_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    axis_nxt  = axis_r;
    case (state_r)
      tcf_pkg::ST_IDLE: begin
        if (stat.in_valid) begin
          state_nxt = tcf_pkg::ST_SQ_A;
          axis_nxt  = 1'b0;
        end
      end
      tcf_pkg::ST_SQ_A: state_nxt = tcf_pkg::ST_SQ_B;
      tcf_pkg::ST_SQ_B: begin
        state_nxt = tcf_pkg::ST_SQRT;
        cnt_nxt   = '0;
      end
      tcf_pkg::ST_SQRT: begin
        if (cnt_r == tcf_pkg::CNT_W'(tcf_pkg::SQRT_STEPS - 1)) begin
          state_nxt = tcf_pkg::ST_CINIT;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      tcf_pkg::ST_CINIT: begin
        state_nxt = tcf_pkg::ST_CORDIC;
        cnt_nxt   = '0;
      end
      tcf_pkg::ST_CORDIC: begin
        if (cnt_r == tcf_pkg::CNT_W'(tcf_pkg::CORDIC_N - 1)) begin
          state_nxt = tcf_pkg::ST_DELTA;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      tcf_pkg::ST_DELTA:   state_nxt = tcf_pkg::ST_BLEND_W;
      tcf_pkg::ST_BLEND_W: state_nxt = tcf_pkg::ST_BLEND_C;
      tcf_pkg::ST_BLEND_C: state_nxt = tcf_pkg::ST_EST;
      tcf_pkg::ST_EST: begin
        if (axis_r) begin
          state_nxt = tcf_pkg::ST_OUT;
        end else begin
          state_nxt = tcf_pkg::ST_SQ_A;
          axis_nxt  = 1'b1;
        end
      end
      tcf_pkg::ST_OUT: begin
        if (stat.out_free) begin
          state_nxt = tcf_pkg::ST_IDLE;
        end
      end
      default: state_nxt = tcf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.op   = tcf_pkg::OP_NOP;
    cmd.axis = axis_r;
    cmd.iter = cnt_r;
    cmd.take = 1'b0;
    case (state_r)
      tcf_pkg::ST_IDLE: begin
        cmd.take = 1'b1;
        if (stat.in_valid) begin
          cmd.op = tcf_pkg::OP_LOAD;
        end
      end
      tcf_pkg::ST_SQ_A:    cmd.op = tcf_pkg::OP_SQ_A;
      tcf_pkg::ST_SQ_B:    cmd.op = tcf_pkg::OP_SQ_B;
      tcf_pkg::ST_SQRT:    cmd.op = tcf_pkg::OP_SQRT;
      tcf_pkg::ST_CINIT:   cmd.op = tcf_pkg::OP_CINIT;
      tcf_pkg::ST_CORDIC:  cmd.op = tcf_pkg::OP_CORDIC;
      tcf_pkg::ST_DELTA:   cmd.op = tcf_pkg::OP_DELTA;
      tcf_pkg::ST_BLEND_W: cmd.op = tcf_pkg::OP_BLEND_W;
      tcf_pkg::ST_BLEND_C: cmd.op = tcf_pkg::OP_BLEND_C;
      tcf_pkg::ST_EST:     cmd.op = tcf_pkg::OP_EST;
      tcf_pkg::ST_OUT: begin
        if (stat.out_free) begin
          cmd.op = tcf_pkg::OP_OUT;
        end
      end
      default: cmd.op = tcf_pkg::OP_NOP;
    endcase
  end

endmodule

@@ hw/rtl/tcf_datapath.sv @@
module tcf_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  tcf_pkg::tcf_cmd_t   cmd,
  output tcf_pkg::tcf_stat_t  stat,
  tcf_in_if.sink              in_ch,
  tcf_out_if.source           out_ch,
  tcf_cfg_if.sink             cfg_ch
);

  logic signed [15:0] off_x_r, off_y_r;
  logic [15:0]        weight_r, scale_r;

  logic signed [15:0] ax_r, ay_r, az_r, rx_r, ry_r;

  logic signed [51:0] acc_r;
  logic signed [25:0] delta_r;
  logic signed [31:0] pitch_est_r, roll_est_r;

  logic [tcf_pkg::SQRT_W-1:0] n_r, res_r, bit_r;
  logic signed [27:0]         x_r, y_r;
  logic signed [24:0]         z_r;

  logic               out_valid_r;
  logic signed [15:0] pitch_out_r, roll_out_r;

  logic signed [15:0] num, a_sel, rate_sel, off_sel;
  logic signed [31:0] est_sel;
  logic signed [16:0] gdiff;
  logic signed [33:0] gyro;
  logic signed [24:0] angle;
  logic signed [17:0] ma;
  logic signed [33:0] mb;
  logic signed [51:0] prod;
  logic signed [51:0] delta_rnd, mix_rnd;
  logic signed [35:0] blend_r;
  logic signed [31:0] blend_sat;
  logic [31:0]        sq_sum;
  logic [tcf_pkg::SQRT_W:0] trial;
  logic signed [27:0] xs, ys;

  function automatic logic signed [15:0] to_q7_8(input logic signed [31:0] est);
    logic signed [32:0] t;
    logic signed [24:0] r;
    t = 33'(est) + 33'sd128;
    r = t[32:8];
    if (r > 25'sd32767) begin
      return 16'sh7fff;
    end else if (r < -25'sd32768) begin
      return -16'sh8000;
    end else begin
      return r[15:0];
    end
  endfunction

  assign num      = cmd.axis ? ay_r : ax_r;
  assign a_sel    = cmd.axis ? ax_r : ay_r;
  assign rate_sel = cmd.axis ? ry_r : rx_r;
  assign off_sel  = cmd.axis ? off_y_r : off_x_r;
  assign est_sel  = cmd.axis ? roll_est_r : pitch_est_r;

  assign gdiff = 17'(rate_sel) - 17'(off_sel);
  assign gyro  = 34'(est_sel) + 34'(delta_r);
  assign angle = (num == 16'sd0) ? 25'sd0 : z_r;

  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd.op)
      tcf_pkg::OP_SQ_A: begin
        ma = 18'(a_sel);
        mb = 34'(a_sel);
      end
      tcf_pkg::OP_SQ_B: begin
        ma = 18'(az_r);
        mb = 34'(az_r);
      end
      tcf_pkg::OP_DELTA: begin
        ma = 18'(gdiff);
        mb = $signed({18'b0, scale_r});
      end
      tcf_pkg::OP_BLEND_W: begin
        ma = $signed({2'b0, weight_r});
        mb = gyro;
      end
      tcf_pkg::OP_BLEND_C: begin
        ma = $signed(18'h10000 - {2'b0, weight_r});
        mb = 34'(angle);
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  assign prod      = ma * mb;
  assign delta_rnd = prod + 52'sd128;
  assign mix_rnd   = acc_r + 52'sd32768;
  assign blend_r   = mix_rnd[51:16];
  assign sq_sum    = acc_r[31:0] + prod[31:0];
  assign trial     = {1'b0, res_r} + {1'b0, bit_r};
  assign xs        = x_r >>> cmd.iter;
  assign ys        = y_r >>> cmd.iter;

  always_comb begin
    if (blend_r > 36'sh07fffffff) begin
      blend_sat = 32'sh7fffffff;
    end else if (blend_r < -36'sh080000000) begin
      blend_sat = -32'sh80000000;
    end else begin
      blend_sat = blend_r[31:0];
    end
  end

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = cmd.take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_x_r  <= '0;
      off_y_r  <= '0;
      weight_r <= tcf_pkg::BLEND_WEIGHT_RST;
      scale_r  <= tcf_pkg::STEP_SCALE_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.idx)
        tcf_pkg::REG_GYRO_OFFSET_X:   off_x_r  <= $signed(cfg_ch.data);
        tcf_pkg::REG_GYRO_OFFSET_Y:   off_y_r  <= $signed(cfg_ch.data);
        tcf_pkg::REG_BLEND_WEIGHT:    weight_r <= cfg_ch.data;
        tcf_pkg::REG_GYRO_STEP_SCALE: scale_r  <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pitch_est_r <= '0;
      roll_est_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.op == tcf_pkg::OP_EST) begin
        if (cmd.axis) begin
          roll_est_r <= blend_sat;
        end else begin
          pitch_est_r <= blend_sat;
        end
      end
      if (cmd.op == tcf_pkg::OP_OUT) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      tcf_pkg::OP_LOAD: begin
        ax_r <= in_ch.accel_x;
        ay_r <= in_ch.accel_y;
        az_r <= in_ch.accel_z;
        rx_r <= in_ch.rate_x;
        ry_r <= in_ch.rate_y;
      end
      tcf_pkg::OP_SQ_A: acc_r <= prod;
      tcf_pkg::OP_SQ_B: begin
        n_r   <= {sq_sum, 16'b0};
        res_r <= '0;
        bit_r <= tcf_pkg::SQRT_W'(1) << (tcf_pkg::SQRT_W - 2);
      end
      tcf_pkg::OP_SQRT: begin
        if ({1'b0, n_r} >= trial) begin
          n_r   <= n_r - trial[tcf_pkg::SQRT_W-1:0];
          res_r <= (res_r >> 1) + bit_r;
        end else begin
          res_r <= res_r >> 1;
        end
        bit_r <= bit_r >> 2;
      end
      tcf_pkg::OP_CINIT: begin
        x_r <= $signed({4'b0, res_r[23:0]});
        y_r <= 28'($signed({num, 8'b0}));
        z_r <= '0;
      end
      tcf_pkg::OP_CORDIC: begin
        if (!y_r[27]) begin
          x_r <= x_r + ys;
          y_r <= y_r - xs;
          z_r <= z_r + tcf_pkg::atan_q16(cmd.iter);
        end else begin
          x_r <= x_r - ys;
          y_r <= y_r + xs;
          z_r <= z_r - tcf_pkg::atan_q16(cmd.iter);
        end
      end
      tcf_pkg::OP_DELTA:   delta_r <= delta_rnd[33:8];
      tcf_pkg::OP_BLEND_W: acc_r <= prod;
      tcf_pkg::OP_BLEND_C: acc_r <= acc_r + prod;
      tcf_pkg::OP_OUT: begin
        pitch_out_r <= to_q7_8(pitch_est_r);
        roll_out_r  <= to_q7_8(roll_est_r);
      end
      default: ;
    endcase
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.pitch_deg = pitch_out_r;
  assign out_ch.roll_deg  = roll_out_r;

  assign stat.in_valid = in_ch.valid;
  assign stat.out_free = !out_valid_r || out_ch.ready;

endmodule

@@ hw/rtl/tilt_complementary_filter.sv @@
// One item is processed at a time: the next input transaction is accepted only after
// the shared square-root unit (24 steps) and CORDIC unit (16 iterations) have run for
// both axes and the result has been loaded into the output register once that is free.
// A finished result waits in the output register while the next item is accepted.
// Reset (rst_n low, synchronous) clears both estimates, loads the register defaults
// and leaves no result pending.
module tilt_complementary_filter (
  input  logic       clk,
  input  logic       rst_n,
  tcf_in_if.sink     in_ch,
  tcf_out_if.source  out_ch,
  tcf_cfg_if.sink    cfg_ch
);

  tcf_pkg::tcf_cmd_t  cmd;
  tcf_pkg::tcf_stat_t stat;

  tcf_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .cmd   (cmd)
  );

  tcf_datapath u_datapath (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (cmd),
    .stat   (stat),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("input accepted twice in a row");

  a_load_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == tcf_pkg::OP_LOAD) == (in_ch.valid && in_ch.ready))
    else $error("input latch out of step with the transaction");

  a_out_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == tcf_pkg::OP_OUT |=> out_ch.valid)
    else $error("result register not valid after load");

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps

module tb;

  typedef struct {
    logic signed [15:0] pitch;
    logic signed [15:0] roll;
  } angles_t;

  typedef struct {
    logic signed [15:0] ax, ay, az, rx, ry;
    bit                 typed;
    logic signed [15:0] pitch, roll;
  } sample_row_t;

  localparam int IDLE_LIMIT = 4000;

  localparam longint ATAN_DEG[24] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  logic clk;
  logic rst_n;

  tcf_in_if  in_ch ();
  tcf_out_if out_ch ();
  tcf_cfg_if cfg_ch ();

  tilt_complementary_filter dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  longint  bias_x, bias_y, alpha, step_scale;
  longint  pitch_est, roll_est;
  angles_t angle_q[$];
  int      mismatches;
  int      idle_cycles;
  int      hold_left;
  bit      no_idle;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic longint unsigned int_root(longint unsigned n);
    longint unsigned res = 0;
    longint unsigned b = 64'h4000_0000_0000_0000;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint tilt_deg(longint num, longint a, longint b);
    longint x, y, z, xs, ys;
    x = longint'(int_root(longint'(a * a + b * b) << 16));
    y = num * 256;
    z = 0;
    if (num == 0) return 0;
    for (int i = 0; i < tcf_pkg::CORDIC_N; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + ATAN_DEG[i];
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - ATAN_DEG[i];
      end
    end
    return z;
  endfunction

  function automatic longint mix_estimate(longint est, longint delta, longint acc);
    longint r;
    r = (alpha * (est + delta) + (65536 - alpha) * acc + 32768) >>> 16;
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    return r;
  endfunction

  function automatic logic signed [15:0] to_q7_8(longint est);
    longint r;
    r = (est + 128) >>> 8;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[15:0];
  endfunction

  function automatic angles_t fuse_sample(longint ax, longint ay, longint az,
                                          longint rx, longint ry);
    angles_t res;
    longint  dx, dy;
    dx = ((rx - bias_x) * step_scale + 128) >>> 8;
    dy = ((ry - bias_y) * step_scale + 128) >>> 8;
    pitch_est = mix_estimate(pitch_est, dx, tilt_deg(ax, ay, az));
    roll_est  = mix_estimate(roll_est, dy, tilt_deg(ay, ax, az));
    res.pitch = to_q7_8(pitch_est);
    res.roll  = to_q7_8(roll_est);
    return res;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d, expected %0d", what, got, want);
    mismatches++;
  endtask

  task automatic write_registers(logic [15:0] ox, logic [15:0] oy,
                                 logic [15:0] w, logic [15:0] s);
    logic [15:0] vals[4];
    vals = '{ox, oy, w, s};
    in_ch.valid <= 1'b0;
    wait (angle_q.size() == 0);
    repeat (110) @(posedge clk);
    for (int i = 0; i < 4; i++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.idx   <= tcf_pkg::CFG_IDX_W'(i);
      cfg_ch.data  <= vals[i];
      @(posedge clk);
      while (!cfg_ch.ready) @(posedge clk);
      case (tcf_pkg::CFG_IDX_W'(i))
        tcf_pkg::REG_GYRO_OFFSET_X:   bias_x = longint'($signed(vals[i]));
        tcf_pkg::REG_GYRO_OFFSET_Y:   bias_y = longint'($signed(vals[i]));
        tcf_pkg::REG_BLEND_WEIGHT:    alpha = longint'(vals[i]);
        tcf_pkg::REG_GYRO_STEP_SCALE: step_scale = longint'(vals[i]);
        default: ;
      endcase
    end
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic send_sample(sample_row_t row);
    int      gap;
    angles_t want;
    gap = no_idle ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.accel_x <= row.ax;
    in_ch.accel_y <= row.ay;
    in_ch.accel_z <= row.az;
    in_ch.rate_x  <= row.rx;
    in_ch.rate_y  <= row.ry;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    want = fuse_sample(row.ax, row.ay, row.az, row.rx, row.ry);
    if (row.typed) begin
      want.pitch = row.pitch;
      want.roll  = row.roll;
    end
    angle_q.push_back(want);
  endtask

  function automatic sample_row_t random_row(int shape);
    sample_row_t row;
    row.typed = 1'b0;
    row.ax = 16'($urandom);
    row.ay = 16'($urandom);
    row.az = 16'($urandom);
    row.rx = 16'($urandom);
    row.ry = 16'($urandom);
    if (shape == 1) begin
      row.ax = $signed(16'($urandom_range(0, 8000))) - 16'sd4000;
      row.ay = $signed(16'($urandom_range(0, 8000))) - 16'sd4000;
      row.az = 16'sd16384 - $signed(16'($urandom_range(0, 2000)));
      row.rx = $signed(16'($urandom_range(0, 600))) - 16'sd300;
      row.ry = $signed(16'($urandom_range(0, 600))) - 16'sd300;
    end else if (shape == 2) begin
      if ($urandom_range(0, 1)) row.ax = 0;
      if ($urandom_range(0, 1)) row.ay = 0;
      if ($urandom_range(0, 1)) row.az = 0;
    end
    return row;
  endfunction

  task automatic random_phase(int count);
    sample_row_t row;
    int          burst;
    for (int n = 0; n < count; n++) begin
      if (burst > 0) begin
        burst--;
      end else begin
        row = random_row($urandom_range(0, 9) < 6 ? 1 : $urandom_range(0, 2));
        if ($urandom_range(0, 30) == 0) burst = $urandom_range(20, 60);
      end
      send_sample(row);
    end
  endtask

  sample_row_t directed[$];

  initial begin
    rst_n          = 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.accel_x <= '0;
    in_ch.accel_y <= '0;
    in_ch.accel_z <= '0;
    in_ch.rate_x  <= '0;
    in_ch.rate_y  <= '0;
    cfg_ch.valid  <= 1'b0;
    cfg_ch.idx    <= '0;
    cfg_ch.data   <= '0;
    bias_x = 0;
    bias_y = 0;
    alpha = longint'(tcf_pkg::BLEND_WEIGHT_RST);
    step_scale = longint'(tcf_pkg::STEP_SCALE_RST);
    pitch_est = 0;
    roll_est = 0;
    no_idle = 1'b0;
    hold_left = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    directed = '{
      '{0, 0, 0, 0, 0, 1, 0, 0},
      '{0, 0, 16384, 0, 0, 1, 0, 0},
      '{32767, 0, 0, 0, 0, 0, 0, 0},
      '{-32768, 0, 0, 0, 0, 0, 0, 0},
      '{0, 32767, 0, 0, 0, 0, 0, 0},
      '{0, -32768, 0, 0, 0, 0, 0, 0},
      '{32767, 32767, 32767, 32767, 32767, 0, 0, 0},
      '{-32768, -32768, -32768, -32768, -32768, 0, 0, 0},
      '{0, 0, -32768, 32767, -32768, 0, 0, 0},
      '{1, -1, 0, -1, 1, 0, 0, 0},
      '{-1, 1, 32767, 0, 0, 0, 0, 0},
      '{16384, 0, 16384, 100, -100, 0, 0, 0},
      '{0, -16384, 16384, -100, 100, 0, 0, 0},
      '{32767, -32768, 1, 32767, 32767, 0, 0, 0},
      '{-32768, 32767, -1, 32767, 32767, 0, 0, 0},
      '{0, 0, 0, 0, 0, 0, 0, 0}
    };
    foreach (directed[i]) send_sample(directed[i]);

    random_phase(250);
    write_registers(16'h8000, 16'h7fff, 16'd0, 16'hffff);
    no_idle = 1'b1;
    random_phase(120);
    no_idle = 1'b0;
    hold_left = 800;
    random_phase(130);
    write_registers(16'h7fff, 16'h8000, 16'hffff, 16'hffff);
    random_phase(250);
    write_registers(16'd37, 16'hffd0, 16'hffff, 16'd0);
    random_phase(250);
    write_registers(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    random_phase(250);
    write_registers(16'd0, 16'd0, 16'd62587, 16'd10230);
    random_phase(285);

    in_ch.valid <= 1'b0;
    wait (angle_q.size() == 0);
    repeat (200) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    stall = $urandom_range(0, 7);
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) stall = no_idle ? 0 : $urandom_range(0, 7);
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    angles_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (angle_q.size() == 0) begin
        $display("unexpected transaction: pitch %0d roll %0d",
                 out_ch.pitch_deg, out_ch.roll_deg);
        mismatches++;
      end else begin
        want = angle_q.pop_front();
        if (out_ch.pitch_deg !== want.pitch)
          report_mismatch("pitch_deg", out_ch.pitch_deg, want.pitch);
        if (out_ch.roll_deg !== want.roll)
          report_mismatch("roll_deg", out_ch.roll_deg, want.roll);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

@@ filelist.f @@
hw/rtl/tcf_pkg.sv
hw/rtl/tcf_in_if.sv
hw/rtl/tcf_out_if.sv
hw/rtl/tcf_cfg_if.sv
hw/rtl/tcf_ctrl.sv
hw/rtl/tcf_datapath.sv
hw/rtl/tilt_complementary_filter.sv
tb/sv/tb.sv
